>>> rtl/utf8_stream_decoder_core_macros.svh
// Assertion macros shared by the UTF-8 stream decoder RTL.
`ifndef UTF8_STREAM_DECODER_CORE_MACROS_SVH
`define UTF8_STREAM_DECODER_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define U8SD_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("u8sd: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define U8SD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("u8sd: next-cycle check failed");

`endif

>>> rtl/u8sd_pkg.sv
// Shared types, constants and the value check of the UTF-8 stream decoder.
package u8sd_pkg;

   localparam int CP_W = 21;

   typedef logic [CP_W-1:0] cp_type;
   typedef logic [2:0]      len_type;

   // Sequence lengths; zero means nothing pending
   localparam len_type LEN_IDLE = 3'd0;
   localparam len_type LEN_1    = 3'd1;
   localparam len_type LEN_2    = 3'd2;
   localparam len_type LEN_3    = 3'd3;
   localparam len_type LEN_4    = 3'd4;
   localparam len_type LEN_5    = 3'd5;
   localparam len_type LEN_6    = 3'd6;

   localparam cp_type UNICODE_MAX  = 21'h10FFFF;
   localparam cp_type SURR_LO      = 21'h00D800;
   localparam cp_type SURR_HI      = 21'h00DFFF;
   localparam cp_type MAX_1BYTE    = 21'h00007F;
   localparam cp_type MAX_2BYTE    = 21'h0007FF;
   localparam cp_type MAX_3BYTE    = 21'h00FFFF;
   localparam cp_type REPL_DEFAULT = 21'h00FFFD;

   // One result as it travels to the back end
   typedef struct packed {
      cp_type  cp;
      logic    broken;
      len_type nbytes;
   } result_type;

   // All results caused by one request (one or two)
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } job_type;

   typedef struct packed {
      logic empty;
      logic full;
   } queue_stat_type;

   // Out of range, surrogate, overlong, or a 5/6-byte form
   function automatic logic seq_bad(input len_type len, input cp_type c);
      logic bad;
      bad = (len > LEN_4) || (c > UNICODE_MAX) || ((c >= SURR_LO) && (c <= SURR_HI))
         || ((len == LEN_2) && (c <= MAX_1BYTE))
         || ((len == LEN_3) && (c <= MAX_2BYTE))
         || ((len == LEN_4) && (c <= MAX_3BYTE));
      return bad;
   endfunction

endpackage

>>> rtl/u8sd_front.sv
// Front end: takes requests, tracks the open sequence and builds result jobs.
module u8sd_front import u8sd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic [7:0]     req_data_byte,
   input  logic           req_end_of_stream,
   input  queue_stat_type q_stat,
   output logic           push,
   output job_type        push_job
);

   typedef enum logic [2:0] {
      BC_ASCII, BC_CONT, BC_LEAD2, BC_LEAD3, BC_LEAD4, BC_LEAD5, BC_LEAD6, BC_INVALID
   } byte_class_type;

   len_type el_ff, el_in;
   len_type bs_ff, bs_in;
   cp_type  acc_ff, acc_in;

   byte_class_type cls;
   logic           accept;
   logic           pending, is_cont, done, do_start;
   len_type        bs_inc;
   cp_type         acc_sh;
   logic           a_v, b_v, c_v;
   result_type     a_res, b_res, c_res;
   logic           sb_emit;
   len_type        sb_len;
   cp_type         sb_acc;
   len_type        mid_el, mid_bs;
   cp_type         mid_acc;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;

   // Byte classification
   always_comb begin
      unique case (req_data_byte) inside
         [8'h00:8'h7F]: cls = BC_ASCII;
         [8'h80:8'hBF]: cls = BC_CONT;
         [8'hC0:8'hDF]: cls = BC_LEAD2;
         [8'hE0:8'hEF]: cls = BC_LEAD3;
         [8'hF0:8'hF4]: cls = BC_LEAD4;
         [8'hF5:8'hFB]: cls = BC_LEAD5;
         [8'hFC:8'hFD]: cls = BC_LEAD6;
         default:       cls = BC_INVALID;
      endcase
   end

   // Fresh-byte handling: single-byte result or a new lead
   always_comb begin
      sb_emit = 1'b0;
      sb_len  = LEN_IDLE;
      sb_acc  = '0;
      b_res   = '{cp: '0, broken: 1'b1, nbytes: LEN_1};
      case (cls)
         BC_ASCII: begin
            sb_emit = 1'b1;
            b_res   = '{cp: {{(CP_W-8){1'b0}}, req_data_byte}, broken: 1'b0, nbytes: LEN_1};
         end
         BC_CONT, BC_INVALID: sb_emit = 1'b1;
         BC_LEAD2: begin
            sb_len = LEN_2;
            sb_acc = {{(CP_W-5){1'b0}}, req_data_byte[4:0]};
         end
         BC_LEAD3: begin
            sb_len = LEN_3;
            sb_acc = {{(CP_W-4){1'b0}}, req_data_byte[3:0]};
         end
         BC_LEAD4: begin
            sb_len = LEN_4;
            sb_acc = {{(CP_W-3){1'b0}}, req_data_byte[2:0]};
         end
         BC_LEAD5: sb_len = LEN_5;
         BC_LEAD6: sb_len = LEN_6;
         default:  sb_emit = 1'b1;
      endcase
   end

   // Pending sequence: extend, finish, or cut short
   always_comb begin
      pending  = (el_ff != LEN_IDLE);
      is_cont  = (cls == BC_CONT);
      bs_inc   = bs_ff + LEN_1;
      acc_sh   = {acc_ff[CP_W-7:0], req_data_byte[5:0]};
      done     = (bs_inc >= el_ff);
      do_start = !pending || !is_cont;

      a_v   = pending && (!is_cont || done);
      a_res = is_cont ? '{cp: acc_sh, broken: seq_bad(el_ff, acc_sh), nbytes: bs_inc}
                      : '{cp: '0, broken: 1'b1, nbytes: bs_ff};
      b_v   = do_start && sb_emit;

      if (pending && is_cont && !done) begin
         mid_el  = el_ff;
         mid_bs  = bs_inc;
         mid_acc = acc_sh;
      end else if (do_start && !sb_emit) begin
         mid_el  = sb_len;
         mid_bs  = LEN_1;
         mid_acc = sb_acc;
      end else begin
         mid_el  = LEN_IDLE;
         mid_bs  = LEN_IDLE;
         mid_acc = '0;
      end

      // End of stream flushes whatever is still open
      c_v   = req_end_of_stream && (mid_el != LEN_IDLE);
      c_res = '{cp: '0, broken: 1'b1, nbytes: mid_bs};

      if (req_end_of_stream) begin
         el_in  = LEN_IDLE;
         bs_in  = LEN_IDLE;
         acc_in = '0;
      end else begin
         el_in  = mid_el;
         bs_in  = mid_bs;
         acc_in = mid_acc;
      end
   end

   // Pack up to two results into one job, in model order
   always_comb begin
      push_job.two = a_v && (b_v || c_v);
      push_job.r0  = a_v ? a_res : (b_v ? b_res : c_res);
      push_job.r1  = b_v ? b_res : c_res;
      push         = accept && (a_v || b_v || c_v);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         el_ff  <= LEN_IDLE;
         bs_ff  <= LEN_IDLE;
         acc_ff <= '0;
      end else if (accept) begin
         el_ff  <= el_in;
         bs_ff  <= bs_in;
         acc_ff <= acc_in;
      end
   end

endmodule

>>> rtl/u8sd_queue.sv
// Job queue between the front and back ends.
module u8sd_queue import u8sd_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  job_type        push_job,
   input  logic           pop,
   output job_type        pop_job,
   output queue_stat_type stat
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff, count_in;

   assign stat.empty = (count_ff == '0);
   assign stat.full  = (count_ff == CNT_FULL);
   assign pop_job    = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) count_in = count_ff + CNT_W'(1);
      else if (!push && pop) count_in = count_ff - CNT_W'(1);
   end

   // Pointers and fill level
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
         if (pop)  rd_ptr_ff <= (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
   end

   // Storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_job;
   end

endmodule

>>> rtl/u8sd_back.sv
// Back end: output register that hands out the results of each job in turn.
module u8sd_back import u8sd_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  queue_stat_type q_stat,
   input  job_type        pop_job,
   output logic           pop,
   input  cp_type         repl,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output cp_type         rsp_code_point,
   output logic           rsp_broken,
   output len_type        rsp_seq_bytes,
   output logic           rsp_last_of_run
);

   job_type    cur_ff;
   logic       valid_ff, valid_in;
   logic       sel_ff, sel_in;
   logic       last, fin, load;
   result_type res;

   assign last = !cur_ff.two || sel_ff;
   assign fin  = valid_ff && rsp_ready && last;
   assign load = (!valid_ff || fin) && !q_stat.empty;
   assign pop  = load;

   // Next control state
   always_comb begin
      valid_in = valid_ff;
      sel_in   = sel_ff;
      if (load) begin
         valid_in = 1'b1;
         sel_in   = 1'b0;
      end else if (fin) begin
         valid_in = 1'b0;
      end else if (valid_ff && rsp_ready) begin
         sel_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         sel_ff   <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         sel_ff   <= sel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) cur_ff <= pop_job;
   end

   // Result selection; broken results carry the replacement code point
   assign res             = sel_ff ? cur_ff.r1 : cur_ff.r0;
   assign rsp_valid       = valid_ff;
   assign rsp_code_point  = res.broken ? repl : res.cp;
   assign rsp_broken      = res.broken;
   assign rsp_seq_bytes   = res.nbytes;
   assign rsp_last_of_run = last;

endmodule

>>> rtl/utf8_stream_decoder_core.sv
// UTF-8 stream decoder top level: front end, job queue, back end, CSR.
//
//   channel   direction  payload                                      handshake
//   req       in         data_byte[7:0], end_of_stream                req_valid/req_ready
//   rsp       out        code_point[20:0], broken, seq_bytes[2:0],    rsp_valid/rsp_ready
//                        last_of_run
//   csr       in         replacement_char[20:0]                       csr_valid/csr_ready
//
// One request per cycle while the queue is not full; a request yields zero, one
// or two results, and the output register issues one result per cycle while
// rsp_ready is high. A result passes from the front end into the queue, then
// into the back-end output register. Synchronous active-high reset clears the
// sequence state, queue and output valid; the replacement char returns to FFFD.
// Requests stall only while the queue is full; csr writes are always taken.
`include "utf8_stream_decoder_core_macros.svh"

module utf8_stream_decoder_core import u8sd_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [20:0] rsp_code_point,
   output logic        rsp_broken,
   output logic [2:0]  rsp_seq_bytes,
   output logic        rsp_last_of_run,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [20:0] csr_replacement_char
);

   queue_stat_type q_stat;
   logic           push, pop;
   job_type        push_job, pop_job;
   cp_type         repl_ff;

   // Replacement code point register
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         repl_ff <= REPL_DEFAULT;
      end else if (csr_valid && csr_ready) begin
         repl_ff <= csr_replacement_char;
      end
   end

   u8sd_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .q_stat            (q_stat),
      .push              (push),
      .push_job          (push_job)
   );

   u8sd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .pop_job  (pop_job),
      .stat     (q_stat)
   );

   u8sd_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_stat          (q_stat),
      .pop_job         (pop_job),
      .pop             (pop),
      .repl            (repl_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_code_point  (rsp_code_point),
      .rsp_broken      (rsp_broken),
      .rsp_seq_bytes   (rsp_seq_bytes),
      .rsp_last_of_run (rsp_last_of_run)
   );

   // Checks
   `U8SD_ASSERT_IMPLY(a_broken_repl, clock, reset, rsp_valid && rsp_broken, rsp_code_point == repl_ff)
   `U8SD_ASSERT_IMPLY(a_good_range, clock, reset, rsp_valid && !rsp_broken, (rsp_code_point <= UNICODE_MAX) && (rsp_seq_bytes != LEN_IDLE) && (rsp_seq_bytes <= LEN_4))
   `U8SD_ASSERT_NEXT(a_pair_follows, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid)
   `U8SD_ASSERT_IMPLY(a_queue_state, clock, reset, q_stat.full, !q_stat.empty)

endmodule

>>> tb/sv/utf8_stream_decoder_core_tb.sv
// Self-checking testbench for the UTF-8 stream decoder core.
module utf8_stream_decoder_core_tb import u8sd_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int SETTLE_TICKS = 4;
   localparam int REPORT_CAP   = 30;

   // One request: a byte and its end-of-stream flag
   typedef struct packed {
      logic [7:0] data;
      logic       eos;
   } stream_byte_type;

   // One decoded result as the block should present it
   typedef struct packed {
      cp_type  cp;
      logic    broken;
      len_type nbytes;
      logic    last;
   } decoded_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_end_of_stream = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [20:0] rsp_code_point;
   logic        rsp_broken;
   logic [2:0]  rsp_seq_bytes;
   logic        rsp_last_of_run;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [20:0] csr_replacement_char = '0;

   stream_byte_type stream_q[$];
   decoded_type     decoded_q[$];
   stream_byte_type next_byte;
   decoded_type     got_result;
   decoded_type     want_result;

   // Decoder state as the testbench tracks it
   cp_type  repl_char = REPL_DEFAULT;
   len_type seq_len   = LEN_IDLE;
   len_type seq_seen  = LEN_IDLE;
   cp_type  seq_acc   = '0;

   int send_idle_pct = 16;
   int recv_idle_pct = 45;
   int mismatch_count = 0;
   int cycle_count = 0;

   utf8_stream_decoder_core uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_data_byte        (req_data_byte),
      .req_end_of_stream    (req_end_of_stream),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_code_point       (rsp_code_point),
      .rsp_broken           (rsp_broken),
      .rsp_seq_bytes        (rsp_seq_bytes),
      .rsp_last_of_run      (rsp_last_of_run),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_replacement_char (csr_replacement_char)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------- decoding

   // Out of range, surrogate, overlong, or a 5/6-byte form
   function automatic logic value_invalid(len_type n, cp_type c);
      return (n > LEN_4) || (c > UNICODE_MAX) || ((c >= SURR_LO) && (c <= SURR_HI))
         || ((n == LEN_2) && (c <= MAX_1BYTE))
         || ((n == LEN_3) && (c <= MAX_2BYTE))
         || ((n == LEN_4) && (c <= MAX_3BYTE));
   endfunction

   function automatic void post_result(cp_type c, logic bad, len_type n);
      decoded_type r;
      r.cp     = bad ? repl_char : c;
      r.broken = bad;
      r.nbytes = n;
      r.last   = 1'b0;
      decoded_q.push_back(r);
   endfunction

   function automatic void clear_seq();
      seq_len  = LEN_IDLE;
      seq_seen = LEN_IDLE;
      seq_acc  = '0;
   endfunction

   // Byte seen with nothing pending: either one result or a new sequence
   function automatic int open_seq(logic [7:0] b);
      if (b <= 8'h7F) begin
         post_result(cp_type'(b), 1'b0, LEN_1);
         return 1;
      end
      if ((b <= 8'hBF) || (b >= 8'hFE)) begin
         post_result('0, 1'b1, LEN_1);
         return 1;
      end
      seq_seen = LEN_1;
      if (b <= 8'hDF) begin
         seq_len = LEN_2;
         seq_acc = cp_type'(b[4:0]);
      end else if (b <= 8'hEF) begin
         seq_len = LEN_3;
         seq_acc = cp_type'(b[3:0]);
      end else if (b <= 8'hF4) begin
         seq_len = LEN_4;
         seq_acc = cp_type'(b[2:0]);
      end else if (b <= 8'hFB) begin
         seq_len = LEN_5;
         seq_acc = '0;
      end else begin
         seq_len = LEN_6;
         seq_acc = '0;
      end
      return 0;
   endfunction

   // Expected results of one accepted request
   function automatic void decode_byte(logic [7:0] b, logic eos);
      int k;
      decoded_type r;
      k = 0;
      if (seq_len != LEN_IDLE) begin
         if (b[7:6] == 2'b10) begin
            seq_seen = seq_seen + 3'd1;
            seq_acc  = {seq_acc[14:0], b[5:0]};
            if (seq_seen >= seq_len) begin
               post_result(seq_acc, value_invalid(seq_len, seq_acc), seq_seen);
               k++;
               clear_seq();
            end
         end else begin
            // cut short: flush what we have, then treat the byte afresh
            post_result('0, 1'b1, seq_seen);
            k++;
            clear_seq();
            k += open_seq(b);
         end
      end else begin
         k += open_seq(b);
      end
      if (eos) begin
         if (seq_len != LEN_IDLE) begin
            post_result('0, 1'b1, seq_seen);
            k++;
         end
         clear_seq();
      end
      if (k > 0) begin
         r = decoded_q.pop_back();
         r.last = 1'b1;
         decoded_q.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_byte(logic [7:0] b, logic eos);
      stream_byte_type s;
      s.data = b;
      s.eos  = eos;
      stream_q.push_back(s);
   endfunction

   // First `take` bytes of a sequence of length len carrying value v;
   // length 1 is a raw byte, lengths 5 and 6 carry random content
   function automatic void push_seq(int len, cp_type v, int take);
      logic [7:0] b;
      for (int j = 0; j < take; j++) begin
         if (j == 0) begin
            case (len)
               1: b = v[7:0];
               2: b = {3'b110, v[10:6]};
               3: b = {4'b1110, v[15:12]};
               4: b = {5'b11110, v[20:18]};
               5: b = 8'($urandom_range(8'hFB, 8'hF5));
               default: b = 8'($urandom_range(8'hFD, 8'hFC));
            endcase
         end else if (len > 4) begin
            b = 8'($urandom_range(8'hBF, 8'h80));
         end else begin
            b = {2'b10, 6'(v >> (6 * (len - 1 - j)))};
         end
         push_byte(b, (j == take - 1) && ($urandom_range(99) < 6));
      end
   endfunction

   // Mostly well-formed text, then the broken forms and plain noise
   function automatic void add_random(int n);
      int made;
      int sel;
      int len;
      int take;
      cp_type v;
      made = 0;
      while (made < n) begin
         sel = $urandom_range(99);
         if (sel < 20) begin
            len = 1;
            v = cp_type'($urandom_range(8'h7F));
         end else if (sel < 40) begin
            len = 2;
            v = cp_type'($urandom_range(21'h7FF, 21'h80));
         end else if (sel < 56) begin
            len = 3;
            v = cp_type'($urandom_range(21'hFFFF, 21'h800));
         end else if (sel < 70) begin
            len = 4;
            v = cp_type'($urandom_range(21'h10FFFF, 21'h10000));
         end else if (sel < 76) begin
            // overlong encodings of lengths 2 to 4
            len = $urandom_range(4, 2);
            v = cp_type'($urandom_range(len == 2 ? 21'h7F : (len == 3 ? 21'h7FF : 21'hFFFF)));
         end else if (sel < 79) begin
            len = 3;
            v = cp_type'($urandom_range(SURR_HI, SURR_LO));
         end else if (sel < 82) begin
            len = 4;
            v = cp_type'($urandom_range(21'h13FFFF, 21'h110000));
         end else if (sel < 86) begin
            len = $urandom_range(6, 5);
            v = '0;
         end else if (sel < 93) begin
            len = $urandom_range(6, 2);
            v = cp_type'($urandom_range(UNICODE_MAX));
         end else begin
            len = 1;
            v = cp_type'($urandom_range(8'hFF));
         end
         take = len;
         if ((sel >= 86) && (sel < 93))
            take = $urandom_range(len - 1, 1);
         push_seq(len, v, take);
         made += take;
      end
      // close the phase so nothing is left pending
      push_byte(8'($urandom_range(8'h7F)), 1'b1);
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < REPORT_CAP)
         $display("%0t mismatch on %s: got %0h, expected %0h", $realtime, field, got, want);
      mismatch_count++;
   endtask

   // Request driver; predicts results at each accepted request
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            decode_byte(req_data_byte, req_end_of_stream);
         if (!req_valid || req_ready) begin
            if ((stream_q.size() > 0) && ($urandom_range(99) >= send_idle_pct)) begin
               next_byte = stream_q.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_byte.data;
               req_end_of_stream <= next_byte.eos;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and receiver back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         if (rsp_valid && rsp_ready) begin
            got_result = {rsp_code_point, rsp_broken, rsp_seq_bytes, rsp_last_of_run};
            if (decoded_q.size() == 0) begin
               report_mismatch("unexpected result", 32'(got_result), 32'h0);
            end else begin
               want_result = decoded_q.pop_front();
               if (got_result.cp !== want_result.cp)
                  report_mismatch("code_point", got_result.cp, want_result.cp);
               if (got_result.broken !== want_result.broken)
                  report_mismatch("broken", got_result.broken, want_result.broken);
               if (got_result.nbytes !== want_result.nbytes)
                  report_mismatch("seq_bytes", got_result.nbytes, want_result.nbytes);
               if (got_result.last !== want_result.last)
                  report_mismatch("last_of_run", got_result.last, want_result.last);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("utf8_stream_decoder_core verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------- sequencing

   // Wait until every request is taken and every result has come back
   task automatic settle();
      while ((stream_q.size() > 0) || req_valid || (decoded_q.size() > 0))
         @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
   endtask

   task automatic write_replacement(input cp_type v);
      @(posedge clock);
      csr_replacement_char <= v;
      csr_valid <= 1'b1;
      do
         @(posedge clock);
      while (!csr_ready);
      repl_char = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: ASCII extremes, stray continuation, FE/FF
      push_byte(8'h00, 1'b0);
      push_byte(8'h7F, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFE, 1'b0);
      push_byte(8'hFF, 1'b0);
      // surrogate, above the Unicode ceiling, 4-byte overlong
      push_seq(3, SURR_LO, 3);
      push_byte(8'hF4, 1'b0);
      push_byte(8'h90, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hF0, 1'b0);
      push_byte(8'h8F, 1'b0);
      push_byte(8'hBF, 1'b0);
      push_byte(8'hBF, 1'b0);
      // 5-byte lead flushed by end of stream
      push_byte(8'hF8, 1'b1);
      // cut short by ASCII: two results from one request
      push_byte(8'hC3, 1'b0);
      push_byte(8'h41, 1'b0);
      // truncated by end of stream
      push_byte(8'hE2, 1'b0);
      push_byte(8'h82, 1'b1);
      // cut short by a lead that end of stream then flushes
      push_byte(8'hE2, 1'b0);
      push_byte(8'hC3, 1'b1);
      settle();

      write_replacement('0);
      add_random(150);
      settle();

      send_idle_pct = 45;
      recv_idle_pct = 16;
      write_replacement(21'h1FFFFF);
      add_random(150);
      settle();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_replacement(UNICODE_MAX);
      add_random(130);
      settle();

      write_replacement(cp_type'($urandom_range(UNICODE_MAX)));
      add_random(100);
      settle();

      if (mismatch_count == 0)
         $display("utf8_stream_decoder_core verification clean");
      else
         $display("utf8_stream_decoder_core verification failed");
      $finish;
   end

endmodule
